FILE: design/arb_pkg.sv
// ----------------------------------------------------------------------------
// arb_pkg: shared types and constants for the ARGB4444-over-RGB565 blender
// Register indexes, reset values, field widths and the pipeline advance type.
// ----------------------------------------------------------------------------
package arb_pkg;

  // Default parameter values
  localparam int ADDR_BITS_DEF = 20;
  localparam int MAX_DIM_DEF   = 1024;

  // Fixed field widths
  localparam int PIX_W        = 16;
  localparam int FRAME_ADDR_W = 20;
  localparam int DIM_W        = 11;
  localparam int POS_W        = 10;
  localparam int CFG_IDX_W    = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_X          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_INVERT = 3'd6;

  // Register reset values
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd480;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd272;
  localparam logic [POS_W-1:0] RECT_X_RST       = 10'd0;
  localparam logic [POS_W-1:0] RECT_Y_RST       = 10'd0;
  localparam logic [DIM_W-1:0] RECT_WIDTH_RST   = 11'd1;
  localparam logic [DIM_W-1:0] RECT_HEIGHT_RST  = 11'd1;

  // Blend arithmetic
  localparam logic [3:0]  ALPHA_FULL  = 4'hF;
  // floor(x/15) == (x*2185) >> 15 for every x below 1024
  localparam logic [11:0] DIV15_MUL   = 12'd2185;
  localparam int          DIV15_SHIFT = 15;

  // Load enables of the two stages after the input register
  typedef struct packed {
    logic s2;
    logic s3;
  } adv_t;

endpackage

FILE: design/arb_blend.sv
// ----------------------------------------------------------------------------
// arb_blend: two-stage ARGB4444-over-RGB565 colour mix
// Stage 2 forms the weighted channel sums, stage 3 divides each by 15.
// ----------------------------------------------------------------------------
module arb_blend (
  input  logic                        clk,
  input  arb_pkg::adv_t               adv,
  input  logic [arb_pkg::PIX_W-1:0]   src_pixel,
  input  logic [arb_pkg::PIX_W-1:0]   bg_pixel,
  output logic [arb_pkg::PIX_W-1:0]   blended_pixel
);

  function automatic logic [5:0] div15(input logic [9:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'(arb_pkg::DIV15_MUL);
    return p[arb_pkg::DIV15_SHIFT+5:arb_pkg::DIV15_SHIFT];
  endfunction

  logic [3:0] alpha;
  logic [3:0] inv_alpha;
  logic [9:0] sum_r_next, sum_g_next, sum_b_next;
  logic [9:0] sum_r, sum_g, sum_b;
  logic [5:0] q_r, q_g, q_b;

  // Source channels are widened to the RGB565 field widths before weighting.
  assign alpha      = src_pixel[15:12];
  assign inv_alpha  = arb_pkg::ALPHA_FULL - alpha;
  assign sum_r_next = 10'({src_pixel[11:8], 1'b0}) * 10'(alpha)
                    + 10'(bg_pixel[15:11]) * 10'(inv_alpha);
  assign sum_g_next = 10'({src_pixel[7:4], 2'b00}) * 10'(alpha)
                    + 10'(bg_pixel[10:5]) * 10'(inv_alpha);
  assign sum_b_next = 10'({src_pixel[3:0], 1'b0}) * 10'(alpha)
                    + 10'(bg_pixel[4:0]) * 10'(inv_alpha);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sum_r <= sum_r_next;
      sum_g <= sum_g_next;
      sum_b <= sum_b_next;
    end
  end

  assign q_r = div15(sum_r);
  assign q_g = div15(sum_g);
  assign q_b = div15(sum_b);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      blended_pixel <= {q_r[4:0], q_g, q_b[4:0]};
    end
  end

endmodule

FILE: design/argb4444_rect_blend_rgb565.sv
// ----------------------------------------------------------------------------
// argb4444_rect_blend_rgb565: rectangle blender, ARGB4444 source over RGB565
// An accepted input beat passes the input, stage-2 and result registers.
// Throughput: one beat per cycle, set by the three-stage pipeline that moves
// whenever its output register is free or being drained.
// Reset (rst, synchronous, active high) empties the pipeline, clears the
// rectangle counters and loads the register defaults.
// ----------------------------------------------------------------------------
module argb4444_rect_blend_rgb565 #(
  parameter int ADDR_BITS = arb_pkg::ADDR_BITS_DEF,
  parameter int MAX_DIM   = arb_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input pixel channel. s_tdata, from bit 0: src_pixel[15:0], bg_pixel[15:0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,
  // Result channel. m_tdata, from bit 0: blended_pixel[15:0],
  // frame_address[19:0], four zero bits. m_tuser: outside_frame.
  // m_tlast: last_pixel.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast,
  // Register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arb_pkg::DIM_W-1:0]         cfg_data
);

  // Counter width, width of a saturated dimension, and a signed width wide
  // enough for a mirrored origin plus a counter offset.
  localparam int CW  = $clog2(MAX_DIM);
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int BW  = (CW > arb_pkg::DIM_W) ? CW : arb_pkg::DIM_W;
  localparam int SW  = BW + 3;
  localparam int PW  = SW + arb_pkg::DIM_W + 1;
  localparam int AXW = (PW > ADDR_BITS) ? PW : ADDR_BITS;
  localparam int OB  = (ADDR_BITS < arb_pkg::FRAME_ADDR_W) ? ADDR_BITS
                                                            : arb_pkg::FRAME_ADDR_W;

  // Configuration registers
  logic [arb_pkg::DIM_W-1:0] frame_width, frame_height, rect_width, rect_height;
  logic [arb_pkg::POS_W-1:0] rect_x, rect_y;
  logic                      vertical_invert;

  // Position inside the rectangle
  logic [CW-1:0] column_count, line_count;
  logic [CW-1:0] column_count_next, line_count_next;

  // Pipeline control
  logic          v1, v2, v3;
  logic          en3;
  arb_pkg::adv_t adv;
  logic          s_acc;

  // Stage 1: input register
  logic [arb_pkg::PIX_W-1:0] s1_src, s1_bg;
  logic [CW-1:0]             s1_col_cnt, s1_line_cnt;
  logic                      s1_last;

  // Stage 2: frame coordinates
  logic signed [SW-1:0] s2_col, s2_lin;
  logic                 s2_last;

  // Stage 3: result register
  logic [arb_pkg::FRAME_ADDR_W-1:0] s3_addr;
  logic                             s3_outside;
  logic                             s3_last;
  logic [arb_pkg::PIX_W-1:0]        s3_pixel;

  // Saturated rectangle size, mirrored origin and end-of-line tests
  logic [DW-1:0]        w_sat, h_sat;
  logic signed [SW-1:0] org_x, org_y, col_next, lin_next;
  logic                 end_line, end_rect;

  // Address and bounds arithmetic for stage 3
  logic signed [SW-1:0]  fw_s, fh_s;
  logic signed [AXW-1:0] addr_full;
  logic                  outside_next;

  // --------------------------------------------------------------------------
  // Register writes. Any write to a defined index restarts the rectangle; an
  // index beyond the list is accepted and dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= arb_pkg::FRAME_WIDTH_RST;
      frame_height    <= arb_pkg::FRAME_HEIGHT_RST;
      rect_x          <= arb_pkg::RECT_X_RST;
      rect_y          <= arb_pkg::RECT_Y_RST;
      rect_width      <= arb_pkg::RECT_WIDTH_RST;
      rect_height     <= arb_pkg::RECT_HEIGHT_RST;
      vertical_invert <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arb_pkg::REG_FRAME_WIDTH:     frame_width     <= cfg_data;
        arb_pkg::REG_FRAME_HEIGHT:    frame_height    <= cfg_data;
        arb_pkg::REG_RECT_X:          rect_x          <= cfg_data[arb_pkg::POS_W-1:0];
        arb_pkg::REG_RECT_Y:          rect_y          <= cfg_data[arb_pkg::POS_W-1:0];
        arb_pkg::REG_RECT_WIDTH:      rect_width      <= cfg_data;
        arb_pkg::REG_RECT_HEIGHT:     rect_height     <= cfg_data;
        arb_pkg::REG_VERTICAL_INVERT: vertical_invert <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Rectangle size is held in the range one to MAX_DIM. A counter that has
  // reached its limit ends its line or the rectangle.
  // --------------------------------------------------------------------------
  always_comb begin
    if (rect_width == '0) begin
      w_sat = DW'(1);
    end else if (32'(rect_width) > MAX_DIM) begin
      w_sat = DW'(MAX_DIM);
    end else begin
      w_sat = DW'(rect_width);
    end
    if (rect_height == '0) begin
      h_sat = DW'(1);
    end else if (32'(rect_height) > MAX_DIM) begin
      h_sat = DW'(MAX_DIM);
    end else begin
      h_sat = DW'(rect_height);
    end
  end

  assign end_line = (DW'(column_count) + DW'(1)) >= w_sat;
  assign end_rect = end_line && ((DW'(line_count) + DW'(1)) >= h_sat);

  always_comb begin
    column_count_next = column_count + CW'(1);
    line_count_next   = line_count;
    if (end_rect) begin
      column_count_next = '0;
      line_count_next   = '0;
    end else if (end_line) begin
      column_count_next = '0;
      line_count_next   = line_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_count   <= '0;
    end else if (cfg_valid && cfg_ready && (32'(cfg_index) <= 32'(arb_pkg::REG_VERTICAL_INVERT))) begin
      column_count <= '0;
      line_count   <= '0;
    end else if (s_acc) begin
      column_count <= column_count_next;
      line_count   <= line_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance. Each stage loads when it is empty or the stage after it
  // loads, so a bubble anywhere lets a new beat in while a result waits.
  // --------------------------------------------------------------------------
  assign en3      = !v3 || m_tready;
  assign adv.s3   = en3;
  assign adv.s2   = !v2 || en3;
  assign s_tready = !v1 || adv.s2;
  assign s_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      if (adv.s2) begin
        v2 <= v1;
      end
      if (adv.s3) begin
        v3 <= v2;
      end
    end
  end

  // Stage 1: the pixels and the position at which they were taken.
  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_src      <= s_tdata[15:0];
      s1_bg       <= s_tdata[31:16];
      s1_col_cnt  <= column_count;
      s1_line_cnt <= line_count;
      s1_last     <= end_rect;
    end
  end

  // Stage 2: the origin, mirrored when vertical invert is set, may be
  // negative; the sum with the position then stays signed.
  always_comb begin
    if (vertical_invert) begin
      org_x = SW'(frame_width) - (SW'(rect_x) + SW'(w_sat));
      org_y = SW'(frame_height) - (SW'(rect_y) + SW'(h_sat));
    end else begin
      org_x = SW'(rect_x);
      org_y = SW'(rect_y);
    end
  end

  assign col_next = org_x + SW'(s1_col_cnt);
  assign lin_next = org_y + SW'(s1_line_cnt);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_col  <= col_next;
      s2_lin  <= lin_next;
      s2_last <= s1_last;
    end
  end

  // Stage 3: bounds check and address. The address wraps as two's complement
  // at ADDR_BITS and is then cut to the 20-bit field. A zero frame dimension
  // simply flags every pixel as outside.
  assign fw_s = SW'(frame_width);
  assign fh_s = SW'(frame_height);

  assign outside_next = (s2_col < 0) || (s2_col >= fw_s)
                     || (s2_lin < 0) || (s2_lin >= fh_s);

  assign addr_full = AXW'(s2_lin) * AXW'($signed({1'b0, frame_width}))
                   + AXW'(s2_col);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      s3_addr    <= arb_pkg::FRAME_ADDR_W'(addr_full[OB-1:0]);
      s3_outside <= outside_next;
      s3_last    <= s2_last;
    end
  end

  // Colour mix runs alongside stages 2 and 3.
  arb_blend u_blend (
    .clk           (clk),
    .adv           (adv),
    .src_pixel     (s1_src),
    .bg_pixel      (s1_bg),
    .blended_pixel (s3_pixel)
  );

  assign m_tvalid = v3;
  assign m_tdata  = {4'b0000, s3_addr, s3_pixel};
  assign m_tuser  = s3_outside;
  assign m_tlast  = s3_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The column counter never reaches the saturated rectangle width.
  assert property (@(posedge clk) disable iff (rst) 32'(column_count) < 32'(w_sat))
    else $error("column counter beyond rectangle width");

  // Taking the last beat of a rectangle returns both counters to the start.
  assert property (@(posedge clk) disable iff (rst)
    s_acc && end_rect |=> (column_count == '0) && (line_count == '0))
    else $error("counters not cleared after last pixel");

  // An empty input register always leaves the input side ready.
  assert property (@(posedge clk) disable iff (rst) !v1 |-> s_tready)
    else $error("input stalled with empty input register");

endmodule

FILE: test/tb_argb4444_rect_blend_rgb565.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_argb4444_rect_blend_rgb565: self-checking bench for the rectangle blender
// Pixels are streamed in with bursty traffic while the result side stalls on
// its own pattern. A tracker class predicts each blended pixel, its frame
// address and its flags, and compares them against the result beats in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [15:0] pixel;
  logic [19:0] address;
  logic        outside;
  logic        last_pix;
} blend_result_t;

class blend_tracker;
  int frame_w, frame_h, org_x, org_y, rect_w, rect_h, invert;
  int col_pos, line_pos;
  int fails;
  blend_result_t pending[$];

  function new();
    frame_w  = arb_pkg::FRAME_WIDTH_RST;
    frame_h  = arb_pkg::FRAME_HEIGHT_RST;
    org_x    = arb_pkg::RECT_X_RST;
    org_y    = arb_pkg::RECT_Y_RST;
    rect_w   = arb_pkg::RECT_WIDTH_RST;
    rect_h   = arb_pkg::RECT_HEIGHT_RST;
    invert   = 0;
    col_pos  = 0;
    line_pos = 0;
    fails    = 0;
  endfunction

  function void report(string what);
    if (fails < 60) $display("ERROR at %0t: %s", $realtime, what);
    fails++;
  endfunction

  function int pending_count();
    return pending.size();
  endfunction

  function longint clamp_dim(int v);
    if (v < 1) return 1;
    if (v > arb_pkg::MAX_DIM_DEF) return arb_pkg::MAX_DIM_DEF;
    return v;
  endfunction

  function int mix(int s, int b, int a);
    return (s * a + b * (15 - a)) / 15;
  endfunction

  // A write to any known register restarts the rectangle.
  function void write_reg(logic [arb_pkg::CFG_IDX_W-1:0] idx,
                          logic [arb_pkg::DIM_W-1:0] data);
    case (idx)
      arb_pkg::REG_FRAME_WIDTH:     frame_w = int'(data);
      arb_pkg::REG_FRAME_HEIGHT:    frame_h = int'(data);
      arb_pkg::REG_RECT_X:          org_x   = int'(data[arb_pkg::POS_W-1:0]);
      arb_pkg::REG_RECT_Y:          org_y   = int'(data[arb_pkg::POS_W-1:0]);
      arb_pkg::REG_RECT_WIDTH:      rect_w  = int'(data);
      arb_pkg::REG_RECT_HEIGHT:     rect_h  = int'(data);
      arb_pkg::REG_VERTICAL_INVERT: invert  = int'(data[0]);
      default:                      return;
    endcase
    col_pos  = 0;
    line_pos = 0;
  endfunction

  function void note_pixel(logic [15:0] src, logic [15:0] bg);
    blend_result_t res;
    longint w, h, ox, oy, col, lin, lin_addr;
    int a, r, g, b;
    bit end_line, end_rect;
    w = clamp_dim(rect_w);
    h = clamp_dim(rect_h);
    a = int'(src[15:12]);
    r = mix(int'(src[11:8]) << 1, int'(bg[15:11]), a);
    g = mix(int'(src[7:4]) << 2, int'(bg[10:5]), a);
    b = mix(int'(src[3:0]) << 1, int'(bg[4:0]), a);
    ox = org_x;
    oy = org_y;
    if (invert != 0) begin
      ox = longint'(frame_w) - (ox + w);
      oy = longint'(frame_h) - (oy + h);
    end
    col      = ox + col_pos;
    lin      = oy + line_pos;
    lin_addr = lin * frame_w + col;
    end_line = (col_pos + 1 >= w);
    end_rect = end_line && (line_pos + 1 >= h);
    res.pixel    = {5'(r), 6'(g), 5'(b)};
    res.address  = lin_addr[19:0];
    res.outside  = (col < 0 || col >= frame_w || lin < 0 || lin >= frame_h);
    res.last_pix = end_rect;
    pending.push_back(res);
    if (end_rect) begin
      col_pos  = 0;
      line_pos = 0;
    end else if (end_line) begin
      col_pos = 0;
      line_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  function void check_pixel(logic [39:0] data, logic user, logic last_bit);
    blend_result_t want;
    if (pending.size() == 0) begin
      report($sformatf("result beat with nothing expected, tdata %h", data));
      return;
    end
    want = pending.pop_front();
    if (data[15:0] !== want.pixel)
      report($sformatf("blended pixel %h, expected %h", data[15:0], want.pixel));
    if (data[35:16] !== want.address)
      report($sformatf("frame address %h, expected %h", data[35:16], want.address));
    if (data[39:36] !== 4'h0)
      report($sformatf("tdata padding %h, expected zero", data[39:36]));
    if (user !== want.outside)
      report($sformatf("outside flag %b, expected %b", user, want.outside));
    if (last_bit !== want.last_pix)
      report($sformatf("last flag %b, expected %b", last_bit, want.last_pix));
  endfunction
endclass

module tb_argb4444_rect_blend_rgb565;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [arb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // Cycles allowed after the last result before touching the registers.
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 2000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic [arb_pkg::CFG_IDX_W-1:0] index;
    logic [arb_pkg::DIM_W-1:0]     data;
  } reg_write_t;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [31:0]                   s_tdata   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [39:0]                   m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [arb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [arb_pkg::DIM_W-1:0]     cfg_data  = '0;

  blend_tracker tracker;
  reg_write_t   reg_writes[$];
  int           items_sent   = 0;
  int           results_seen = 0;
  int           burst_left   = 0;

  rx_mode_t     rx_mode  = RX_ALWAYS;
  logic [7:0]   rx_mask  = 8'h01;
  int           rx_count = 0;

  argb4444_rect_blend_rgb565 dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // The result side switches between stall behaviours at random: always ready,
  // mostly ready, rarely ready, or a fixed bit pattern.
  // The pattern always has bit 0 set so that it can never stall for good.
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode  <= rx_mode_t'($urandom_range(0, 3));
      rx_mask  <= 8'($urandom) | 8'h01;
      rx_count <= $urandom_range(16, 96);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      RX_ALWAYS:  m_tready <= 1'b1;
      RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
      RX_RARELY:  m_tready <= ($urandom_range(0, 3) == 0);
      default:    m_tready <= rx_mask[rx_count[2:0]];
    endcase
  end

  // All three channels are watched from one block, so the order in which a
  // beat reaches the tracker never depends on the simulator's scheduling.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) tracker.note_pixel(s_tdata[15:0], s_tdata[31:16]);
      if (m_tvalid && m_tready) begin
        tracker.check_pixel(m_tdata, m_tuser, m_tlast);
        results_seen++;
      end
    end
  end

  // Offers one pixel beat and waits for it to be taken. The valid stays high
  // into the next beat unless the current burst has run out, in which case a
  // short gap follows before a new burst length is drawn. Now and then a
  // long burst gives a stretch with no idling at all.
  task automatic send_pixel(input logic [15:0] src, input logic [15:0] bg);
    s_tvalid <= 1'b1;
    s_tdata  <= {bg, src};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Random pixel; fully transparent and fully opaque alpha get extra weight.
  task automatic send_random_pixel();
    logic [15:0] src;
    src = 16'($urandom);
    case ($urandom_range(0, 7))
      0: src[15:12] = 4'h0;
      1: src[15:12] = arb_pkg::ALPHA_FULL;
      default: ;
    endcase
    send_pixel(src, 16'($urandom));
  endtask

  // Stops sending and waits until a result has come back for every beat
  // that was sent, then lets the pipeline settle.
  task automatic drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (results_seen < items_sent || tracker.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_reg(input logic [arb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [arb_pkg::DIM_W-1:0] data);
    reg_writes.push_back('{idx, data});
  endtask

  // Registers are only written with the block idle, so drain first, then
  // issue the queued writes back to back.
  task automatic reconfigure();
    reg_write_t wr;
    drain();
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.index;
      cfg_data  <= wr.data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Dimension for a frame or a rectangle: usually small, sometimes zero,
  // the saturation bound, the top of the field or anything in between.
  function automatic logic [arb_pkg::DIM_W-1:0] pick_size(input int unsigned common_max);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 11'(arb_pkg::MAX_DIM_DEF);
      2:       return '1;
      3:       return 11'($urandom_range(arb_pkg::MAX_DIM_DEF + 1, 2047));
      4:       return 11'($urandom);
      default: return 11'($urandom_range(1, common_max));
    endcase
  endfunction

  function automatic logic [arb_pkg::DIM_W-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0:       return 11'(10'h3FF);
      1:       return 11'($urandom);
      default: return 11'($urandom_range(0, 12));
    endcase
  endfunction

  initial begin
    bit paused_once;
    int random_start;
    int phase_items;
    paused_once = 1'b0;
    tracker = new();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults give a single-pixel rectangle at the frame origin, so
    // every beat is a last pixel at address zero. Exercise the blend corners.
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hF000, 16'hFFFF);
    send_pixel(16'h0FFF, 16'h0000);
    send_pixel(16'h8A5C, 16'h1234);
    send_pixel(16'h7ABC, 16'hFEDC);

    // Small frame with a rectangle that hangs over its right edge.
    queue_reg(arb_pkg::REG_FRAME_WIDTH, 11'd4);
    queue_reg(arb_pkg::REG_FRAME_HEIGHT, 11'd3);
    queue_reg(arb_pkg::REG_RECT_X, 11'd2);
    queue_reg(arb_pkg::REG_RECT_Y, 11'd1);
    queue_reg(arb_pkg::REG_RECT_WIDTH, 11'd3);
    queue_reg(arb_pkg::REG_RECT_HEIGHT, 11'd2);
    queue_reg(arb_pkg::REG_VERTICAL_INVERT, 11'd0);
    reconfigure();
    repeat (6) send_random_pixel();

    // Mirroring in a one-pixel frame puts the origin at a negative position,
    // so the addresses wrap and every pixel is outside.
    queue_reg(arb_pkg::REG_VERTICAL_INVERT, 11'd1);
    queue_reg(arb_pkg::REG_FRAME_WIDTH, 11'd1);
    queue_reg(arb_pkg::REG_FRAME_HEIGHT, 11'd1);
    reconfigure();
    repeat (6) send_random_pixel();

    // Zero frame dimensions, a zero width saturating up to one and an
    // oversized height saturating down to the maximum.
    queue_reg(arb_pkg::REG_VERTICAL_INVERT, 11'd0);
    queue_reg(arb_pkg::REG_FRAME_WIDTH, 11'd0);
    queue_reg(arb_pkg::REG_FRAME_HEIGHT, 11'd0);
    queue_reg(arb_pkg::REG_RECT_WIDTH, 11'd0);
    queue_reg(arb_pkg::REG_RECT_HEIGHT, 11'h7FF);
    reconfigure();
    repeat (3) send_random_pixel();
    // A write past the register list must leave the line counter running.
    queue_reg(REG_UNUSED, 11'h7FF);
    reconfigure();
    repeat (2) send_random_pixel();

    // Saturated sizes also feed the mirrored origin.
    queue_reg(arb_pkg::REG_RECT_WIDTH, 11'h7FF);
    queue_reg(arb_pkg::REG_RECT_HEIGHT, 11'd0);
    queue_reg(arb_pkg::REG_VERTICAL_INVERT, 11'd1);
    queue_reg(arb_pkg::REG_FRAME_WIDTH, 11'(arb_pkg::MAX_DIM_DEF));
    queue_reg(arb_pkg::REG_FRAME_HEIGHT, 11'(arb_pkg::MAX_DIM_DEF));
    queue_reg(arb_pkg::REG_RECT_X, 11'(10'h3FF));
    queue_reg(arb_pkg::REG_RECT_Y, 11'(10'h3FF));
    reconfigure();
    repeat (3) send_random_pixel();

    // Random phases: a random subset of registers is rewritten, then a run of
    // pixels follows. Small rectangles dominate so that many complete.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 6) queue_reg(arb_pkg::REG_FRAME_WIDTH, pick_size(24));
      if ($urandom_range(0, 9) < 6) queue_reg(arb_pkg::REG_FRAME_HEIGHT, pick_size(24));
      if ($urandom_range(0, 9) < 6) queue_reg(arb_pkg::REG_RECT_X, pick_pos());
      if ($urandom_range(0, 9) < 6) queue_reg(arb_pkg::REG_RECT_Y, pick_pos());
      if ($urandom_range(0, 9) < 6) queue_reg(arb_pkg::REG_RECT_WIDTH, pick_size(6));
      if ($urandom_range(0, 9) < 6) queue_reg(arb_pkg::REG_RECT_HEIGHT, pick_size(6));
      if ($urandom_range(0, 9) < 6)
        queue_reg(arb_pkg::REG_VERTICAL_INVERT, 11'($urandom));
      if ($urandom_range(0, 9) == 0) queue_reg(REG_UNUSED, 11'($urandom));
      if (reg_writes.size() == 0) queue_reg(arb_pkg::REG_RECT_WIDTH, pick_size(6));
      reconfigure();
      phase_items = $urandom_range(10, 150);
      repeat (phase_items) begin
        send_random_pixel();
        // Once, midway, hold the input until the pipeline has emptied.
        if (!paused_once && items_sent - random_start >= RANDOM_ITEMS / 2) begin
          paused_once = 1'b1;
          drain();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
